[hw/rtl/socks_pkg.sv]
// Package for the SOCKS5 request parser: types, codes and constants.
package socks_pkg;

    // Parse phase, one-hot
    typedef enum logic [10:0] {
        PH_VER     = 11'b000_0000_0001,
        PH_CMD     = 11'b000_0000_0010,
        PH_RSV     = 11'b000_0000_0100,
        PH_ATYP    = 11'b000_0000_1000,
        PH_DLEN    = 11'b000_0001_0000,
        PH_ADDR    = 11'b000_0010_0000,
        PH_PORT    = 11'b000_0100_0000,
        PH_DONE    = 11'b000_1000_0000,
        PH_BADCMD  = 11'b001_0000_0000,
        PH_BADATYP = 11'b010_0000_0000,
        PH_EMPTY   = 11'b100_0000_0000
    } t_phase;

    // Role of each byte
    typedef enum logic [2:0] {
        ROLE_VERSION  = 3'd0,
        ROLE_COMMAND  = 3'd1,
        ROLE_RESERVED = 3'd2,
        ROLE_ATYP     = 3'd3,
        ROLE_DLEN     = 3'd4,
        ROLE_ADDRESS  = 3'd5,
        ROLE_PORT     = 3'd6,
        ROLE_IGNORED  = 3'd7
    } t_role;

    // Parse status
    typedef enum logic [2:0] {
        ST_MORE    = 3'd0,
        ST_DONE    = 3'd1,
        ST_BADCMD  = 3'd2,
        ST_BADATYP = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    localparam logic [7:0] CMD_CONNECT = 8'd1;
    localparam logic [7:0] ATYP_IPV4   = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN = 8'd3;
    localparam logic [7:0] ATYP_IPV6   = 8'd4;
    localparam logic [8:0] IPV4_BYTES  = 9'd4;
    localparam logic [8:0] IPV6_BYTES  = 9'd16;

    // One registered input byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } t_in_item;

    // One result, as it leaves the parser core
    typedef struct packed {
        t_role      byte_role;
        logic [7:0] byte_offset;
        t_status    status;
        logic [7:0] address_type;
        logic [15:0] dest_port;
        logic [7:0] version_seen;
    } t_result;

endpackage

[hw/rtl/socks_if.sv]
// Stream interfaces for request bytes in and tagged results out.
interface socks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface socks_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  byte_offset;
    logic [2:0]  status;
    logic [7:0]  address_type;
    logic [15:0] dest_port;
    logic [7:0]  version_seen;

    modport source (output valid, output byte_role, output byte_offset, output status,
                    output address_type, output dest_port, output version_seen,
                    input ready);
    modport sink   (input valid, input byte_role, input byte_offset, input status,
                    input address_type, input dest_port, input version_seen,
                    output ready);
endinterface

[hw/rtl/socks_in_stage.sv]
// Input register stage: holds one accepted request byte for the core.
module socks_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    socks_in_if.sink            i_in,
    input  logic                i_take,
    output logic                o_vld,
    output socks_pkg::t_in_item o_item
);
    import socks_pkg::*;

    logic     r_vld;
    t_in_item r_item;
    logic     accept;

    // Free when empty or when the held byte moves on this cycle
    assign i_in.ready = !r_vld || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.in_byte <= i_in.in_byte;
            r_item.restart <= i_in.restart;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule

[hw/rtl/socks_core.sv]
// Parser core: phase machine, counters and kept fields; tags one byte per transfer.
module socks_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  socks_pkg::t_in_item i_item,
    output socks_pkg::t_result  o_result
);
    import socks_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_dlen, n_dlen;
    logic [7:0] r_port_hi, n_port_hi;
    logic [7:0] r_port_lo, n_port_lo;
    logic [7:0] r_atyp, n_atyp;
    logic [7:0] r_ver, n_ver;

    t_phase     c_phase;
    logic [7:0] c_count, c_dlen, c_port_hi, c_port_lo, c_atyp, c_ver;
    logic [8:0] addr_size;
    logic [8:0] offset_next;
    logic [7:0] b;
    t_role      role;
    logic [7:0] offset;
    t_status    status;

    assign b = i_item.in_byte;

    // Restart clears everything before the byte is taken
    always_comb begin
        if (i_item.restart) begin
            c_phase   = PH_VER;
            c_count   = '0;
            c_dlen    = '0;
            c_port_hi = '0;
            c_port_lo = '0;
            c_atyp    = '0;
            c_ver     = '0;
        end else begin
            c_phase   = r_phase;
            c_count   = r_count;
            c_dlen    = r_dlen;
            c_port_hi = r_port_hi;
            c_port_lo = r_port_lo;
            c_atyp    = r_atyp;
            c_ver     = r_ver;
        end
    end

    // Address length by type; domain uses the received length byte
    always_comb begin
        if (c_atyp == ATYP_IPV4) begin
            addr_size = IPV4_BYTES;
        end else if (c_atyp == ATYP_IPV6) begin
            addr_size = IPV6_BYTES;
        end else begin
            addr_size = {1'b0, c_dlen};
        end
    end

    assign offset_next = {1'b0, c_count} + 9'd1;

    // Phase step
    always_comb begin
        n_phase   = c_phase;
        n_count   = c_count;
        n_dlen    = c_dlen;
        n_port_hi = c_port_hi;
        n_port_lo = c_port_lo;
        n_atyp    = c_atyp;
        n_ver     = c_ver;
        role      = ROLE_IGNORED;
        offset    = '0;
        status    = ST_MORE;
        unique case (c_phase)
            PH_VER: begin
                role    = ROLE_VERSION;
                n_ver   = b;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                role = ROLE_COMMAND;
                if (b == CMD_CONNECT) begin
                    n_phase = PH_RSV;
                end else begin
                    status  = ST_BADCMD;
                    n_phase = PH_BADCMD;
                end
            end
            PH_RSV: begin
                role    = ROLE_RESERVED;
                n_phase = PH_ATYP;
            end
            PH_ATYP: begin
                role    = ROLE_ATYP;
                n_count = '0;
                if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
                    n_atyp  = b;
                    n_phase = PH_ADDR;
                end else if (b == ATYP_DOMAIN) begin
                    n_atyp  = b;
                    n_phase = PH_DLEN;
                end else begin
                    status  = ST_BADATYP;
                    n_phase = PH_BADATYP;
                end
            end
            PH_DLEN: begin
                role    = ROLE_DLEN;
                n_dlen  = b;
                n_count = '0;
                if (b == 8'd0) begin
                    status  = ST_EMPTY;
                    n_phase = PH_EMPTY;
                end else begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                role    = ROLE_ADDRESS;
                offset  = c_count;
                n_count = offset_next[7:0];
                if (offset_next >= addr_size) begin
                    n_count = '0;
                    n_phase = PH_PORT;
                end
            end
            PH_PORT: begin
                role   = ROLE_PORT;
                offset = {7'd0, c_count[0]};
                if (!c_count[0]) begin
                    n_port_hi = b;
                    n_count   = 8'd1;
                end else begin
                    n_port_lo = b;
                    n_count   = '0;
                    status    = ST_DONE;
                    n_phase   = PH_DONE;
                end
            end
            PH_DONE:    status = ST_DONE;
            PH_BADCMD:  status = ST_BADCMD;
            PH_BADATYP: status = ST_BADATYP;
            PH_EMPTY:   status = ST_EMPTY;
            default: ;
        endcase
    end

    // Result; kept fields only shown once complete
    always_comb begin
        o_result.byte_role   = role;
        o_result.byte_offset = offset;
        o_result.status      = status;
        if (status == ST_DONE) begin
            o_result.address_type = n_atyp;
            o_result.dest_port    = {n_port_hi, n_port_lo};
            o_result.version_seen = n_ver;
        end else begin
            o_result.address_type = '0;
            o_result.dest_port    = '0;
            o_result.version_seen = '0;
        end
    end

    // State update on each byte handed to the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_VER;
            r_count   <= '0;
            r_dlen    <= '0;
            r_port_hi <= '0;
            r_port_lo <= '0;
            r_atyp    <= '0;
            r_ver     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_dlen    <= n_dlen;
            r_port_hi <= n_port_hi;
            r_port_lo <= n_port_lo;
            r_atyp    <= n_atyp;
            r_ver     <= n_ver;
        end
    end
endmodule

[hw/rtl/socks_out_stage.sv]
// Output register stage: holds one tagged result until the sink takes it.
module socks_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  socks_pkg::t_result i_result,
    output logic               o_room,
    socks_out_if.source        o_out
);
    import socks_pkg::*;

    logic    r_vld;
    t_result r_result;

    // Room when empty or the held result leaves this cycle
    assign o_room = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_vld;
    assign o_out.byte_role    = r_result.byte_role;
    assign o_out.byte_offset  = r_result.byte_offset;
    assign o_out.status       = r_result.status;
    assign o_out.address_type = r_result.address_type;
    assign o_out.dest_port    = r_result.dest_port;
    assign o_out.version_seen = r_result.version_seen;
endmodule

[hw/rtl/socks5_request_parser.sv]
// Top level of the SOCKS5 request parser.
// Takes one request byte per transfer and returns one tagged result per byte: role, offset
// within the address or port, and parse status; address type, port and version appear when
// the status reads complete. Throughput is one byte per clock while the output is not
// stalled; a byte is held in the input register and its result then in the result register
// around the parser core, whose phase and counters update once per byte. A stalled output
// backs up into the input register and then drops input ready. Restart set on a byte
// returns the parser to the version phase before that byte is parsed.
module socks5_request_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    socks_in_if.sink    i_in,
    socks_out_if.source o_out
);
    import socks_pkg::*;

    logic     in_vld;
    t_in_item in_item;
    logic     out_room;
    logic     fire;
    t_result  result;

    // A byte moves from input register to result register
    assign fire = in_vld && out_room;

    socks_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (fire),
        .o_vld   (in_vld),
        .o_item  (in_item)
    );

    socks_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_result (result)
    );

    socks_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (result),
        .o_room   (out_room),
        .o_out    (o_out)
    );
endmodule
